// ===== sv/ordered_list_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// concurrent check wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check sampled on clk, idle while reset is asserted
`define OLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check sampled on clk, also active during reset
`define OLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLE_ASSERT(lbl, prop, msg)
`define OLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ordered list engine package
// shared constants, op and status codes, cell control bundle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ole_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int WORD_W    = 32;
	localparam int CNT_W     = 7;   // holds any count up to the largest depth
	localparam int MAX_OUT   = 32;  // results per dump at most

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_INSERT   = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_DUMP_FWD = 3'd3,
		OP_DUMP_REV = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD    = 3'd0,
		CMD_INSERT  = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_ROT_FWD = 3'd3,
		CMD_ROT_REV = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t           cmd;
		logic [CNT_W-1:0]    pos;
		logic [CNT_W-1:0]    count;
		logic [WORD_W-1:0]   value;
	} cell_ctrl_t;

endpackage

// ===== sv/ole_cell.sv =====
// ----------------------------------------------------------------------------
// ordered list engine cell
// one list slot: holds a word, shifts toward either neighbor on command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ole_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  ole_pkg::cell_ctrl_t        ctrl,
	input  logic [ole_pkg::WORD_W-1:0] left_value,
	input  logic [ole_pkg::WORD_W-1:0] right_value,
	input  logic                       seen_in,
	output logic [ole_pkg::WORD_W-1:0] value_q,
	output logic                       seen_out
);
	import ole_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] IDX1_C = CNT_W'(IDX + 1);

	logic [WORD_W-1:0] value_nxt;
	logic              occupied;

	assign occupied = IDX_C < ctrl.count;
	// first match at or before this slot
	assign seen_out = seen_in | (occupied && (value_q == ctrl.value));

	always_comb begin
		value_nxt = value_q;
		unique case (ctrl.cmd)
			CMD_INSERT: begin
				if (IDX_C == ctrl.pos)
					value_nxt = ctrl.value;
				else if (IDX_C > ctrl.pos)
					value_nxt = left_value;
			end
			CMD_REMOVE: begin
				if (seen_out)
					value_nxt = right_value;
			end
			CMD_ROT_FWD: begin
				if (IDX1_C == ctrl.count)
					value_nxt = ctrl.value;
				else if (IDX1_C < ctrl.count)
					value_nxt = right_value;
			end
			CMD_ROT_REV: begin
				if (IDX_C == '0)
					value_nxt = ctrl.value;
				else if (occupied)
					value_nxt = left_value;
			end
			default: value_nxt = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

endmodule

// ===== sv/ole_chain.sv =====
// ----------------------------------------------------------------------------
// ordered list engine cell chain
// row of list cells with neighbor links, head and tail taps, match chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ole_chain #(
	parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  ole_pkg::cell_ctrl_t        ctrl,
	output logic [ole_pkg::WORD_W-1:0] head_value,
	output logic [ole_pkg::WORD_W-1:0] tail_value,
	output logic                       seen_any
);
	import ole_pkg::*;

	logic [WORD_W-1:0] cell_value [DEPTH];
	logic [DEPTH:0]    seen;

	assign seen[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_v;
		logic [WORD_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cell_value[i];
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end

		ole_cell #(.IDX(i)) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.left_value  (left_v),
			.right_value (right_v),
			.seen_in     (seen[i]),
			.value_q     (cell_value[i]),
			.seen_out    (seen[i+1])
		);
	end

	assign head_value = cell_value[0];
	assign seen_any   = seen[DEPTH];

	// tail tap: slot count-1, and-or over the row
	always_comb begin
		tail_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (ctrl.count == CNT_W'(i + 1))
				tail_value = tail_value | cell_value[i];
		end
	end

endmodule

// ===== sv/ordered_list_engine_core.sv =====
// append, insert, remove, unused ops and dumps of an empty list give their one result
// in the cycle after accept
// dumps first enter the dump state, then stream one entry per cycle into the result register
// while the result channel does not stall; one single-result op per cycle unless it stalls;
// a dump holds the input until its last entry is stepped, and longer while the channel stalls
// reset (arst_n low): list empty, no result pending; cell words stay undefined
`timescale 1ns / 1ps
`include "ordered_list_engine_core_defines.svh"
// ----------------------------------------------------------------------------
// ordered list engine core
// ordered word list kept in a shifting cell chain with append, insert,
// remove by value and forward and reverse dumps
// ----------------------------------------------------------------------------

module ordered_list_engine_core #(
	parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               op_valid,
	output logic               op_stall,
	input  logic [2:0]         op,
	input  logic [5:0]         position,
	input  logic signed [31:0] value,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] item_value,
	output logic [4:0]         item_index,
	output logic [2:0]         status,
	output logic [5:0]         list_length,
	output logic               last
);
	import ole_pkg::*;

	localparam int               CW      = $clog2(DEPTH + 1);
	localparam logic [CW-1:0]    DEPTH_C = CW'(DEPTH);
	localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_OUT);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;       // dump step
	logic              rev_q;     // reverse dump

	// output register
	logic              res_valid_q;
	logic [WORD_W-1:0] item_value_q;
	logic [4:0]        item_index_q;
	status_t           status_q;
	logic [5:0]        length_q;
	logic              last_q;

	cell_ctrl_t        ctrl;
	logic [WORD_W-1:0] head_value;
	logic [WORD_W-1:0] tail_value;
	logic              seen_any;

	logic              load_ok;
	logic              accept;
	logic [CNT_W-1:0]  count7;
	logic [CNT_W-1:0]  k7;
	logic [CNT_W-1:0]  nout7;
	logic              dump_step;
	logic              dump_emit;
	logic [CW-1:0]     dump_idx;

	// next-state values for a single-result op
	logic              single_load;
	status_t           single_status;
	logic [CW-1:0]     count_nxt;
	logic              start_dump;

	// result slot frees when empty or drained this cycle
	assign load_ok  = !res_valid_q || !res_stall;
	assign op_stall = (state_q != S_IDLE) || !load_ok;
	assign accept   = op_valid && !op_stall;

	assign count7 = CNT_W'(count_q);
	assign k7     = CNT_W'(k_q);
	assign nout7  = (count7 > MAX_C) ? MAX_C : count7;

	// past the result cap the rotation keeps going silently to restore order
	assign dump_emit = (state_q == S_DUMP) && (k7 < MAX_C);
	assign dump_step = (state_q == S_DUMP) && (load_ok || !(k7 < MAX_C));
	assign dump_idx  = rev_q ? (count_q - CW'(1) - k_q) : k_q;

	// request decode and chain command
	always_comb begin
		ctrl.cmd      = CMD_HOLD;
		ctrl.pos      = CNT_W'(position);
		ctrl.count    = count7;
		ctrl.value    = value;
		single_load   = 1'b0;
		single_status = ST_OK;
		count_nxt     = count_q;
		start_dump    = 1'b0;

		if (state_q == S_DUMP) begin
			ctrl.value = rev_q ? tail_value : head_value;
			if (dump_step)
				ctrl.cmd = rev_q ? CMD_ROT_REV : CMD_ROT_FWD;
		end else if (accept) begin
			single_load = 1'b1;
			case (op)
				OP_APPEND: begin
					if (count_q == DEPTH_C) begin
						single_status = ST_FULL;
					end else begin
						ctrl.cmd  = CMD_INSERT;
						ctrl.pos  = count7;
						count_nxt = count_q + CW'(1);
					end
				end
				OP_INSERT: begin
					// an empty list takes the word at the head whatever the position
					if (count_q == '0) begin
						ctrl.cmd  = CMD_INSERT;
						ctrl.pos  = '0;
						count_nxt = CW'(1);
					end else if (count_q == DEPTH_C) begin
						single_status = ST_FULL;
					end else if (CNT_W'(position) > count7) begin
						single_status = ST_BADPOS;
					end else begin
						ctrl.cmd  = CMD_INSERT;
						count_nxt = count_q + CW'(1);
					end
				end
				OP_REMOVE: begin
					if (count_q == '0) begin
						single_status = ST_EMPTY;
					end else if (!seen_any) begin
						single_status = ST_NOTFOUND;
					end else begin
						ctrl.cmd  = CMD_REMOVE;
						count_nxt = count_q - CW'(1);
					end
				end
				OP_DUMP_FWD, OP_DUMP_REV: begin
					if (count_q == '0) begin
						single_status = ST_EMPTY;
					end else begin
						single_load = 1'b0;
						start_dump  = 1'b1;
					end
				end
				default: single_status = ST_OK;
			endcase
		end
	end

	ole_chain #(.DEPTH(DEPTH)) u_chain (
		.clk        (clk),
		.ctrl       (ctrl),
		.head_value (head_value),
		.tail_value (tail_value),
		.seen_any   (seen_any)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
			rev_q   <= 1'b0;
		end else begin
			count_q <= count_nxt;
			unique case (state_q)
				S_IDLE: begin
					if (start_dump) begin
						state_q <= S_DUMP;
						k_q     <= '0;
						rev_q   <= (op == OP_DUMP_REV);
					end
				end
				S_DUMP: begin
					if (dump_step) begin
						k_q <= k_q + CW'(1);
						if (k_q + CW'(1) == count_q)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (single_load || (dump_step && dump_emit)) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (single_load) begin
			item_value_q <= '0;
			item_index_q <= '0;
			status_q     <= single_status;
			length_q     <= 6'(count_nxt);
			last_q       <= 1'b1;
		end else if (dump_step && dump_emit) begin
			item_value_q <= rev_q ? tail_value : head_value;
			item_index_q <= 5'(dump_idx);
			status_q     <= ST_OK;
			length_q     <= 6'(count_q);
			last_q       <= (k7 + CNT_W'(1) == nout7);
		end
	end

	assign res_valid   = res_valid_q;
	assign item_value  = item_value_q;
	assign item_index  = item_index_q;
	assign status      = status_q;
	assign list_length = length_q;
	assign last        = last_q;

	`OLE_ASSERT(a_count_range, count_q <= DEPTH_C, "entry count above depth")
	`OLE_ASSERT(a_dump_nonempty, (state_q == S_DUMP) |-> (count_q != '0), "dump of empty list")
	`OLE_ASSERT(a_append_grows, (accept && op == OP_APPEND && count_q != DEPTH_C) |=> (count_q == $past(count_q) + CW'(1)), "append did not grow list")
	`OLE_ASSERT_ALWAYS(a_dump_blocks, (state_q == S_DUMP) |-> op_stall, "request taken during dump")

endmodule
